// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_ON(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Checked at every edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- sv/utf8w_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package utf8w_pkg;

    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int REP_W       = 3;
    localparam int DWID_W      = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_LEN2    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_LEN3    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_LEN4    = 21'h010000;

    localparam logic [DWID_W-1:0] WIDTH_ZERO   = 2'd0;
    localparam logic [DWID_W-1:0] WIDTH_NORMAL = 2'd1;
    localparam logic [DWID_W-1:0] WIDTH_WIDE   = 2'd2;

    // One command per input byte that yields results:
    // rep_cnt replacements first, then the decoded character if has_char.
    typedef struct packed {
        logic [REP_W-1:0] rep_cnt;
        logic             has_char;
        logic [CP_W-1:0]  cp;
        logic [LEN_W-1:0] len;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    function automatic logic in_rng(input logic [CP_W-1:0] cp,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        in_rng = (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic [DWID_W-1:0] width_of(input logic [CP_W-1:0] cp);
        logic zero_w;
        logic wide_w;
        zero_w = (cp == '0) || in_rng(cp, 21'h0300, 21'h036F) ||
                 (cp == 21'h200B) || (cp == 21'h200D) ||
                 in_rng(cp, 21'hFE00, 21'hFE0F);
        wide_w = in_rng(cp, 21'h1100, 21'h115F) || in_rng(cp, 21'h2E80, 21'hA4CF) ||
                 in_rng(cp, 21'hAC00, 21'hD7A3) || in_rng(cp, 21'hF900, 21'hFAFF) ||
                 in_rng(cp, 21'hFE30, 21'hFE6F) || in_rng(cp, 21'hFF00, 21'hFF60) ||
                 in_rng(cp, 21'hFFE0, 21'hFFE6) || in_rng(cp, 21'h1F300, 21'h1F64F) ||
                 in_rng(cp, 21'h20000, 21'h3FFFD);
        if (zero_w)
            width_of = WIDTH_ZERO;
        else if (wide_w)
            width_of = WIDTH_WIDE;
        else
            width_of = WIDTH_NORMAL;
    endfunction

endpackage
`default_nettype wire

// ----- sv/utf8w_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module utf8w_front
    import utf8w_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output logic            push,
    output cmd_t            cmd
);

    logic [1:0]      pend_cnt_reg, pend_cnt_next;
    logic [LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [CP_W-1:0] pval_reg, pval_next;

    logic            is_cont, is_ascii, is_l2, is_l3, is_l4;
    logic [2:0]      cnt;
    logic [CP_W-1:0] pv_sh;
    logic            bad;

    assign is_cont  = (text_byte[7:6] == 2'b10);
    assign is_ascii = !text_byte[7];
    assign is_l2    = (text_byte[7:5] == 3'b110);
    assign is_l3    = (text_byte[7:4] == 4'b1110);
    assign is_l4    = (text_byte[7:3] == 5'b11110);
    assign cnt      = {1'b0, pend_cnt_reg} + 3'd1;
    assign pv_sh    = {pval_reg[CP_W-7:0], text_byte[5:0]};
    assign bad      = ((exp_len_reg == 3'd2) && (pv_sh < MIN_LEN2)) ||
                      ((exp_len_reg == 3'd3) && (pv_sh < MIN_LEN3)) ||
                      ((exp_len_reg == 3'd4) && (pv_sh < MIN_LEN4)) ||
                      (exp_len_reg < 3'd2) || (exp_len_reg > 3'd4) ||
                      (pv_sh > MAX_SCALAR) ||
                      ((pv_sh >= SURR_LO) && (pv_sh <= SURR_HI));

    always_comb
    begin
        pend_cnt_next = pend_cnt_reg;
        exp_len_next  = exp_len_reg;
        pval_next     = pval_reg;
        cmd.rep_cnt   = '0;
        cmd.has_char  = 1'b0;
        cmd.cp        = {{(CP_W-8){1'b0}}, text_byte};
        cmd.len       = 3'd1;
        if ((pend_cnt_reg != 2'd0) && is_cont)
        begin
            if (cnt >= exp_len_reg)
            begin
                if (bad)
                    cmd.rep_cnt = cnt;
                else
                begin
                    cmd.has_char = 1'b1;
                    cmd.cp       = pv_sh;
                    cmd.len      = exp_len_reg;
                end
                pend_cnt_next = 2'd0;
                exp_len_next  = '0;
                pval_next     = '0;
            end
            else
            begin
                pend_cnt_next = cnt[1:0];
                pval_next     = pv_sh;
            end
        end
        else
        begin
            // no sequence pending or a broken one: flush what is buffered, then decode afresh
            cmd.rep_cnt   = {1'b0, pend_cnt_reg};
            pend_cnt_next = 2'd0;
            exp_len_next  = '0;
            pval_next     = '0;
            priority if (is_ascii)
                cmd.has_char = 1'b1;
            else if (is_l2)
            begin
                pend_cnt_next = 2'd1;
                exp_len_next  = 3'd2;
                pval_next     = {{(CP_W-5){1'b0}}, text_byte[4:0]};
            end
            else if (is_l3)
            begin
                pend_cnt_next = 2'd1;
                exp_len_next  = 3'd3;
                pval_next     = {{(CP_W-4){1'b0}}, text_byte[3:0]};
            end
            else if (is_l4)
            begin
                pend_cnt_next = 2'd1;
                exp_len_next  = 3'd4;
                pval_next     = {{(CP_W-3){1'b0}}, text_byte[2:0]};
            end
            else
                cmd.rep_cnt = cmd.rep_cnt + 3'd1;
        end
        if (end_of_text && (pend_cnt_next != 2'd0))
        begin
            cmd.rep_cnt   = cmd.rep_cnt + {1'b0, pend_cnt_next};
            pend_cnt_next = 2'd0;
            exp_len_next  = '0;
            pval_next     = '0;
        end
    end

    assign push = accept && ((cmd.rep_cnt != '0) || cmd.has_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_cnt_reg <= 2'd0;
            exp_len_reg  <= '0;
            pval_reg     <= '0;
        end
        else if (accept)
        begin
            pend_cnt_reg <= pend_cnt_next;
            exp_len_reg  <= exp_len_next;
            pval_reg     <= pval_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/utf8w_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module utf8w_fifo
    import utf8w_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      din,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ----- sv/utf8w_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module utf8w_back
    import utf8w_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  cmd_t                    head,
    input  wire logic               q_empty,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [CP_W-1:0]         code_point,
    output logic [LEN_W-1:0]        byte_count,
    output logic                    well_formed,
    output logic [DWID_W-1:0]       display_width,
    output logic                    last_of_run
);

    logic               valid_reg;
    logic [REP_W-1:0]   rem_rep_reg;
    logic               char_reg;
    logic [CP_W-1:0]    cp_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [DWID_W-1:0]  dwid_reg;
    logic               taken, done;

    assign out_valid   = valid_reg;
    assign taken       = valid_reg && out_ready;
    assign last_of_run = ((rem_rep_reg == 3'd1) && !char_reg) ||
                         ((rem_rep_reg == 3'd0) && char_reg);
    assign done        = taken && last_of_run;
    assign pop         = !q_empty && (!valid_reg || done);

    // replacements go out before the decoded character
    always_comb
    begin
        if (rem_rep_reg != '0)
        begin
            code_point    = REPLACEMENT;
            byte_count    = 3'd1;
            well_formed   = 1'b0;
            display_width = WIDTH_NORMAL;
        end
        else
        begin
            code_point    = cp_reg;
            byte_count    = len_reg;
            well_formed   = 1'b1;
            display_width = dwid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cp_reg   <= head.cp;
            len_reg  <= head.len;
            dwid_reg <= width_of(head.cp);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            rem_rep_reg <= '0;
            char_reg    <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg   <= 1'b1;
            rem_rep_reg <= head.rep_cnt;
            char_reg    <= head.has_char;
        end
        else if (done)
            valid_reg <= 1'b0;
        else if (taken)
        begin
            if (rem_rep_reg != '0)
                rem_rep_reg <= rem_rep_reg - 1'b1;
            else
                char_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

// ----- sv/strict_utf8_decoder_width_unit.sv -----
// Path: a byte's command is written into the command queue, then loaded into the output register once it is free.
// Throughput: one byte per cycle; a byte that causes n results gives n output transactions,
//   and input stalls only once the command queue (QUEUE_DEPTH) fills.
// Reset: rst_n asynchronous, active low; clears decoder state, queue and output.
`timescale 1ns / 1ps
`default_nettype none
module strict_utf8_decoder_width_unit
    import utf8w_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [20:0] code_point, [23:21] byte_count,
                                        // [24] well_formed, [26:25] display_width
    output logic             m_tlast    // last_of_run
);

    // Front: byte classification and sequence state, one command per byte
    // transaction that yields results. Back: expands a command into results.
    cmd_t              f_cmd, q_head;
    logic              f_push, q_full, q_empty, q_pop, s_accept;
    logic [CP_W-1:0]   o_cp;
    logic [LEN_W-1:0]  o_len;
    logic              o_ok;
    logic [DWID_W-1:0] o_wid;

    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    utf8w_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .text_byte   (s_tdata),
        .end_of_text (s_tlast),
        .push        (f_push),
        .cmd         (f_cmd)
    );

    utf8w_fifo #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .din   (f_cmd),
        .pop   (q_pop),
        .dout  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    utf8w_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_empty       (q_empty),
        .pop           (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .code_point    (o_cp),
        .byte_count    (o_len),
        .well_formed   (o_ok),
        .display_width (o_wid),
        .last_of_run   (m_tlast)
    );

    assign m_tdata = {5'b0, o_wid, o_ok, o_len, o_cp};

endmodule
`default_nettype wire

// ----- sv/utf8w_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module utf8w_check
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    `ASSERT_ALWAYS(a_idle_in_reset, clk, !rst_n |-> !m_tvalid)
    `ASSERT_ON(a_valid_holds, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid)
    `ASSERT_ON(a_data_holds, clk, rst_n,
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    `ASSERT_ON(a_repl_fields, clk, rst_n,
        m_tvalid && !m_tdata[24] |->
            m_tdata[20:0] == 21'h00FFFD && m_tdata[23:21] == 3'd1 &&
            m_tdata[26:25] == 2'd1)
    `ASSERT_ON(a_good_fields, clk, rst_n,
        m_tvalid && m_tdata[24] |->
            m_tdata[23:21] != 3'd0 && m_tdata[23:21] <= 3'd4 &&
            m_tdata[26:25] != 2'd3 && m_tdata[31:27] == 5'd0)

endmodule

bind strict_utf8_decoder_width_unit utf8w_check u_check (.*);
`default_nettype wire
